// ----- rtl/lis_pkg.sv -----
package lis_pkg;

    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 7;
    localparam int DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_core_state;

    typedef enum logic [1:0] {
        SR_IDLE,
        SR_READ,
        SR_CMP
    } t_srch_state;

endpackage

// ----- rtl/lis_if.sv -----
interface lis_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lis_pkg::VALUE_W-1:0]   value;
    logic                                 first;

    modport source (output valid, output value, output first, input ready);
    modport sink   (input valid, input value, input first, output ready);
endinterface

interface lis_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [lis_pkg::LENGTH_W-1:0]  length;
    logic                                 overflow;

    modport source (output valid, output length, output overflow, input ready);
    modport sink   (input valid, input length, input overflow, output ready);
endinterface

// ----- rtl/longest_increasing_subsequence_core.sv -----
// Streaming longest strictly increasing subsequence (patience sorting). Each input
// transaction carries a signed 32-bit value; first=1 empties the tail table before the
// value is taken. One output transaction follows each input with the current length and a
// sticky overflow flag, set when an append to a full table of DEPTH tails is refused.
// Each item is searched with at most ceil(log2(count+1)) binary-search probes; each probe
// is a read of the tail RAM (registered read) followed by one signed compare. The next
// input is taken while a result still waits on the output. The tail RAM is not cleared
// after reset; only entries below the current length are ever read.
module longest_increasing_subsequence_core #(
    parameter int DEPTH = lis_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lis_in_if.sink    i_in,
    lis_out_if.source o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DepthC = CW'(DEPTH);

    lis_pkg::t_core_state r_state, n_state;
    logic [CW-1:0]                       r_count, n_count;
    logic                                r_ovf, n_ovf;
    logic signed [lis_pkg::VALUE_W-1:0]  r_value, n_value;
    logic                                r_out_valid, n_out_valid;
    logic [lis_pkg::LENGTH_W-1:0]        r_out_len, n_out_len;
    logic                                r_out_ovf, n_out_ovf;

    logic                                w_accept;
    logic                                w_we;
    logic [AW-1:0]                       w_waddr;
    logic [AW-1:0]                       w_raddr;
    logic signed [lis_pkg::VALUE_W-1:0]  w_rdata;
    logic                                w_done;
    logic [CW-1:0]                       w_idx;

    assign i_in.ready     = (r_state == lis_pkg::ST_IDLE);
    assign w_accept       = i_in.valid && i_in.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.length   = r_out_len;
    assign o_out.overflow = r_out_ovf;

    lis_search #(
        .DEPTH (DEPTH)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_in.value),
        .i_hi    (n_count),
        .i_rdata (w_rdata),
        .o_raddr (w_raddr),
        .o_done  (w_done),
        .o_idx   (w_idx)
    );

    lis_ram #(
        .WIDTH (lis_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_tails (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lis_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_value   <= n_value;
        r_out_len <= n_out_len;
        r_out_ovf <= n_out_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_value     = r_value;
        n_out_valid = r_out_valid;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        w_we        = 1'b0;
        w_waddr     = w_idx[AW-1:0];

        // drop the result once the sink takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lis_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_value = i_in.value;
                    if (i_in.first) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                    n_state = lis_pkg::ST_SEARCH;
                end
            end
            lis_pkg::ST_SEARCH: begin
                if (w_done) begin
                    // search ran off the end: every tail is below the value, so append
                    if (w_idx == r_count) begin
                        if (r_count == DepthC) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        w_we = 1'b1;
                    end
                    n_state = lis_pkg::ST_FINISH;
                end
            end
            lis_pkg::ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_len   = lis_pkg::LENGTH_W'(r_count);
                    n_out_ovf   = r_ovf;
                    n_state     = lis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lis_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lis_ram.sv -----
module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lis_search.sv -----
module lis_search #(
    parameter int DEPTH = lis_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [lis_pkg::VALUE_W-1:0]  i_key,
    input  logic [$clog2(DEPTH+1)-1:0]          i_hi,
    input  logic signed [lis_pkg::VALUE_W-1:0]  i_rdata,
    output logic [$clog2(DEPTH)-1:0]            o_raddr,
    output logic                                o_done,
    output logic [$clog2(DEPTH+1)-1:0]          o_idx
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    lis_pkg::t_srch_state r_state, n_state;
    logic [CW-1:0]                       r_lo, n_lo;
    logic [CW-1:0]                       r_hi, n_hi;
    logic [CW-1:0]                       r_mid, n_mid;
    logic signed [lis_pkg::VALUE_W-1:0]  r_key, n_key;
    logic [CW-1:0]                       w_mid;

    assign w_mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign o_raddr = w_mid[AW-1:0];
    assign o_idx   = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lis_pkg::SR_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        o_done  = 1'b0;
        case (r_state)
            lis_pkg::SR_IDLE: begin
                if (i_start) begin
                    n_lo    = '0;
                    n_hi    = i_hi;
                    n_key   = i_key;
                    n_state = lis_pkg::SR_READ;
                end
            end
            lis_pkg::SR_READ: begin
                // probe the middle tail, or finish once the window is empty
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = lis_pkg::SR_CMP;
                end else begin
                    o_done  = 1'b1;
                    n_state = lis_pkg::SR_IDLE;
                end
            end
            lis_pkg::SR_CMP: begin
                if (i_rdata < r_key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = lis_pkg::SR_READ;
            end
            default: begin
                n_state = lis_pkg::SR_IDLE;
            end
        endcase
    end

endmodule
